### rtl/pfra_pkg.sv
// Shared types, codes and defaults for the per-flow rate adjuster.
// No dependencies; imported by pfra_flow_mem and per_flow_rate_adjuster.
package pfra_pkg;

  localparam int FLOWS_DEF = 256;

  localparam int ID_W     = 8;
  localparam int RATE_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int CMD_W    = 2;
  localparam int MARK_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Q0.16: one is 2^16, so (1 - w) needs 17 bits
  localparam int FRAC_SH = 16;
  localparam int KEEP_W  = WEIGHT_W + 1;
  localparam logic [KEEP_W-1:0] FRAC_ONE = KEEP_W'(1) << FRAC_SH;

  // command codes
  localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;

  // notification marks
  localparam logic [MARK_W-1:0] MARK_INC = 2'd0;
  localparam logic [MARK_W-1:0] MARK_DEC = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W_FLOOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_CEIL    = 2'd3;

  // configuration reset values
  localparam logic                ENABLE_RST    = 1'b1;
  localparam logic [RATE_W-1:0]   LINK_RATE_RST = 32'd100000000;
  localparam logic [WEIGHT_W-1:0] W_FLOOR_RST   = 16'd1638;
  localparam logic [WEIGHT_W-1:0] W_CEIL_RST    = 16'd32768;

  typedef struct packed {
    logic                valid;
    logic [RATE_W-1:0]   rate;
    logic [WEIGHT_W-1:0] weight;
  } flow_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } pfra_state_t;

endpackage

### rtl/pfra_flow_mem.sv
// Flow table storage: one write port, one read port, registered read data.
// Depends on pfra_pkg for the entry type.
module pfra_flow_mem
  import pfra_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF,
  parameter int AW    = $clog2(FLOWS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  flow_entry_t       wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output flow_entry_t       rd_data
);

  flow_entry_t mem [FLOWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/per_flow_rate_adjuster.sv
// Per-flow rate adjuster: sender rate table for a PCN-style congestion control.
// Depends on pfra_pkg and pfra_flow_mem.
//
// One transaction in gives one transaction out. Each flow entry (valid, rate
// in kb/s, Q0.16 weight) lives in a single-port-read, single-port-write
// synchronous memory. A transaction runs through the memory read, a stage
// of parallel registered products of up to 32x17 bits, then the update,
// write-back and result load. The next transaction is taken once the
// previous one has written back, so there is never a read of an entry with
// a write still pending; a held result only delays the write-back step when
// the output register is still occupied. After reset the table is swept
// clear, one entry a cycle, so the block takes no transaction until the
// sweep is done; configuration writes are taken throughout. Flow indexes at
// or above FLOWS report a miss and leave the table alone.
module per_flow_rate_adjuster
  import pfra_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // command channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [ID_W-1:0]       in_flow_id,
  input  logic [MARK_W-1:0]     in_ecn_mark,
  input  logic [RATE_W-1:0]     in_receive_rate,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [RATE_W-1:0]     out_rate_out,
  output logic [WEIGHT_W-1:0]   out_weight_out
);

  localparam int AW    = $clog2(FLOWS);
  localparam int RK_W  = RATE_W + KEEP_W;     // rate * (1 - w)
  localparam int LW_W  = RATE_W + WEIGHT_W;   // rate * w
  localparam int WK_W  = WEIGHT_W + KEEP_W;   // w * (1 - w)
  localparam int MW_W  = WEIGHT_W + WEIGHT_W; // weight ceiling * w

  // configuration registers
  logic                enable_r;
  logic [RATE_W-1:0]   link_rate_r;
  logic [WEIGHT_W-1:0] w_floor_r;
  logic [WEIGHT_W-1:0] w_ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RST;
      link_rate_r <= LINK_RATE_RST;
      w_floor_r   <= W_FLOOR_RST;
      w_ceil_r    <= W_CEIL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE:    enable_r    <= cfg_wdata[0];
        CFG_LINK_RATE: link_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_W_FLOOR:   w_floor_r   <= cfg_wdata[WEIGHT_W-1:0];
        CFG_W_CEIL:    w_ceil_r    <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  pfra_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic          accept;
  logic          commit;
  logic          out_free;

  // memory ports
  logic        mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  flow_entry_t mem_wr_data;
  flow_entry_t mem_rd_data;

  // latched transaction
  logic [CMD_W-1:0]  cmd_r;
  logic [AW-1:0]     idx_r;
  logic              in_range_r;
  logic [MARK_W-1:0] mark_r;

  // stage after the read: entry and products
  flow_entry_t       ent_r;
  logic [RK_W-1:0]   p_rk_r;
  logic [LW_W-1:0]   p_lw_r;
  logic [WK_W-1:0]   p_wk_r;
  logic [MW_W-1:0]   p_mw_r;
  logic [RK_W-1:0]   p_rx_r;
  logic [RATE_W-1:0] rx_r;

  // output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic [WEIGHT_W-1:0] out_weight_r;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    commit    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(FLOWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold the write-back until the result has somewhere to go
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // latch the transaction; the read is issued on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      idx_r      <= AW'(in_flow_id);
      in_range_r <= 32'(in_flow_id) < 32'(FLOWS);
      mark_r     <= in_ecn_mark;
      rx_r       <= in_receive_rate;
    end
  end

  // product stage: every multiply is registered before it is summed
  logic [KEEP_W-1:0] keep;
  logic [KEEP_W-1:0] dec_keep;

  assign keep     = FRAC_ONE - KEEP_W'(mem_rd_data.weight);
  assign dec_keep = FRAC_ONE - KEEP_W'(w_floor_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      ent_r  <= mem_rd_data;
      p_rk_r <= RK_W'(mem_rd_data.rate) * RK_W'(keep);
      p_lw_r <= LW_W'(link_rate_r) * LW_W'(mem_rd_data.weight);
      p_wk_r <= WK_W'(mem_rd_data.weight) * WK_W'(keep);
      p_mw_r <= MW_W'(w_ceil_r) * MW_W'(mem_rd_data.weight);
      p_rx_r <= RK_W'(rx_r) * RK_W'(dec_keep);
    end
  end

  // update
  flow_entry_t       ent_new;
  logic [RATE_W-1:0] dec_target;
  logic [RATE_W-1:0] inc_rate;
  logic [WEIGHT_W-1:0] inc_weight;

  // rx * (1 - floor) never exceeds rx, so the top bit is always zero
  assign dec_target = p_rx_r[FRAC_SH +: RATE_W];
  assign inc_rate   = p_rk_r[FRAC_SH +: RATE_W] + p_lw_r[FRAC_SH +: RATE_W];
  assign inc_weight = p_wk_r[FRAC_SH +: WEIGHT_W] + p_mw_r[FRAC_SH +: WEIGHT_W];

  always_comb begin
    ent_new = ent_r;
    case (cmd_r)
      CMD_OPEN: begin
        if (enable_r && !ent_r.valid) begin
          ent_new.valid  = 1'b1;
          ent_new.rate   = link_rate_r;
          ent_new.weight = w_floor_r;
        end
      end
      CMD_NOTIFY: begin
        if (ent_r.valid) begin
          if (mark_r == MARK_DEC) begin
            if (ent_r.rate > dec_target) begin
              ent_new.rate = dec_target;
            end
            ent_new.weight = w_floor_r;
          end else if (mark_r == MARK_INC) begin
            ent_new.rate   = inc_rate;
            ent_new.weight = inc_weight;
          end
        end
      end
      CMD_CLOSE: begin
        ent_new.valid = 1'b0;
      end
      default: ;
    endcase
  end

  // write port: clearing sweep, then write-back of updates
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_r;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = commit && in_range_r;
      mem_wr_addr = idx_r;
      mem_wr_data = ent_new;
    end
  end

  pfra_flow_mem #(
    .FLOWS (FLOWS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (AW'(in_flow_id)),
    .rd_data (mem_rd_data)
  );

  // result register
  logic hit;
  assign hit = in_range_r && ent_new.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r    <= hit;
      out_rate_r   <= hit ? ent_new.rate : '0;
      out_weight_r <= hit ? ent_new.weight : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_rate_out   = out_rate_r;
  assign out_weight_out = out_weight_r;

endmodule
